### hdl/kmce_pkg.sv
// ----------------------------------------------------------------------------
// kmce_pkg
// Shared types, widths and the keymap table of the key matrix change encoder.
// ----------------------------------------------------------------------------
package kmce_pkg;

  // matrix geometry held in the input item and in the keymap table
  localparam int NUM_ROWS   = 5;
  localparam int NUM_COLS   = 14;
  localparam int NUM_LAYERS = 2;
  localparam int ROW_W      = 14;
  localparam int ROW_IDX_W  = 3;
  localparam int COL_IDX_W  = 4;
  localparam int KEY_W      = 7;
  localparam int CODE_W     = 8;

  // stream widths, padded to whole bytes
  localparam int IN_W  = 72;
  localparam int OUT_W = 40;

  // layer select and both-shift mask, taken from row 3
  localparam int          LAYER_BIT  = 13;
  localparam int          SHIFT_ROW  = 3;
  localparam logic [13:0] SHIFT_BOTH = 14'h1001;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  // one key event
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key;
    logic              press;
    logic              valid;
  } event_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic push_needed;
    logic out_free;
  } status_t;

  // two-layer keymap, indexed [layer][row][column]
  localparam logic [7:0] KEYMAP [NUM_LAYERS][NUM_ROWS][NUM_COLS] = '{
    '{
      '{8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
        8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A},
      '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
        8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31},
      '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
        8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h00, 8'h28},
      '{8'hE1, 8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05,
        8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h00},
      '{8'hE0, 8'hE3, 8'hE2, 8'h00, 8'h00, 8'h2C, 8'h00,
        8'h00, 8'h00, 8'h50, 8'h52, 8'h51, 8'h4F, 8'h00}
    },
    '{
      '{8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h4C},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h48, 8'h4A, 8'h4D, 8'h49},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'hF5, 8'h00, 8'hF0,
        8'h00, 8'h7F, 8'h00, 8'hF1, 8'hF2, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'hF3, 8'h81, 8'h80, 8'hF4, 8'h00}
    }
  };

endpackage

### hdl/kmce_ctrl.sv
// ----------------------------------------------------------------------------
// kmce_ctrl
// Scan sequencer: takes a scan, steps the datapath through it and closes it
// with the final result.
// ----------------------------------------------------------------------------
module kmce_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kmce_pkg::status_t status_i,
  output kmce_pkg::cmd_t    cmd_o
);
  import kmce_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_FINAL;
        end else if (!status_i.push_needed || status_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/kmce_datapath.sv
// ----------------------------------------------------------------------------
// kmce_datapath
// Previous scan store, change mask walk, keymap lookup, event pairing and the
// output register.
// ----------------------------------------------------------------------------
module kmce_datapath #(
  parameter int ROWS   = 5,
  parameter int COLS   = 14,
  parameter int LAYERS = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [kmce_pkg::IN_W-1:0]  in_data_i,
  input  kmce_pkg::cmd_t             cmd_i,
  output kmce_pkg::status_t          status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [kmce_pkg::OUT_W-1:0] out_data_o,
  output logic                       out_last_o
);
  import kmce_pkg::*;

  // rows and columns that take part in the scan
  localparam int NROWS = (ROWS < NUM_ROWS) ? ROWS : NUM_ROWS;
  localparam int NCOLS = (COLS < NUM_COLS) ? COLS : NUM_COLS;
  localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((32'd1 << NCOLS) - 32'd1);

  logic [ROW_W-1:0]     prev_q [NUM_ROWS];
  logic [ROW_W-1:0]     diff_q [NUM_ROWS];
  logic [ROW_IDX_W-1:0] row_q;
  logic [1:0]           cnt_q;
  event_t               slot0_q, slot1_q;
  logic                 layer_q, unlock_q;
  logic                 out_valid_q, out_last_q;
  logic [OUT_W-1:0]     out_data_q;

  logic [ROW_W-1:0]     cur [NUM_ROWS];
  logic [ROW_W-1:0]     row_bits;
  logic [COL_IDX_W-1:0] col_sel;
  logic                 has_evt, scan_done, out_free, push;
  event_t               evt;

  // one result item: two slots, layer and the end-of-scan flags
  function automatic logic [OUT_W-1:0] pack_result(event_t s0, event_t s1, logic lay,
                                                   logic unl, logic rep);
    return {3'b000, rep, unl, lay,
            s1.code, s1.key, s1.press, s1.valid,
            s0.code, s0.key, s0.press, s0.valid};
  endfunction

  // split the incoming scan into rows
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      cur[r] = in_data_i[r*ROW_W +: ROW_W];
    end
  end

  // changed bits of the row being walked
  assign scan_done = (row_q == ROW_IDX_W'(NROWS));
  assign row_bits  = scan_done ? '0 : (diff_q[row_q] & COL_MASK);
  assign has_evt   = |row_bits;

  // lowest changed column
  always_comb begin
    col_sel = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (row_bits[i]) begin
        col_sel = COL_IDX_W'(i);
      end
    end
  end

  // event for that column; prev already holds the current scan
  always_comb begin
    evt       = '0;
    evt.valid = 1'b1;
    evt.press = scan_done ? 1'b0 : prev_q[row_q][col_sel];
    evt.key   = KEY_W'(row_q) * KEY_W'(COLS) + KEY_W'(col_sel);
    evt.code  = scan_done ? '0 : KEYMAP[layer_q][row_q][col_sel];
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign push     = cmd_i.step && has_evt && (cnt_q == 2'd2);

  assign status_o.scan_done   = scan_done;
  assign status_o.push_needed = has_evt && (cnt_q == 2'd2);
  assign status_o.out_free    = out_free;

  // control state and the previous scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        prev_q[r] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        row_q <= '0;
        cnt_q <= '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
          prev_q[r] <= cur[r];
        end
      end else if (cmd_i.step) begin
        if (has_evt) begin
          cnt_q <= (cnt_q == 2'd2) ? 2'd1 : cnt_q + 2'd1;
        end else begin
          row_q <= row_q + ROW_IDX_W'(1);
        end
      end
      if (push || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // change masks, event slots and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        diff_q[r] <= cur[r] ^ prev_q[r];
      end
      layer_q  <= (LAYERS > 1) ? cur[SHIFT_ROW][LAYER_BIT] : 1'b0;
      unlock_q <= (cur[SHIFT_ROW] & SHIFT_BOTH) == SHIFT_BOTH;
      slot0_q  <= '0;
      slot1_q  <= '0;
    end else if (cmd_i.step && has_evt) begin
      diff_q[row_q][col_sel] <= 1'b0;
      case (cnt_q)
        2'd0: begin
          slot0_q <= evt;
        end
        2'd1: begin
          slot1_q <= evt;
        end
        default: begin
          slot0_q <= evt;
          slot1_q <= '0;
        end
      endcase
    end
    if (push) begin
      out_data_q <= pack_result(slot0_q, slot1_q, layer_q, 1'b0, 1'b0);
      out_last_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_data_q <= pack_result(slot0_q, slot1_q, layer_q, unlock_q, !unlock_q);
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/key_matrix_change_encoder.sv
// ----------------------------------------------------------------------------
// key_matrix_change_encoder
// Compares each matrix scan with the last one and streams the changed keys
// as press and release events with keymap codes, two events per item.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   one scan: five 14-bit rows
//  m_axis    out  two event slots, layer, unlock/report flags; tlast ends scan
//
//  a scan is loaded, walked with one step per changed key and one per row,
//  the walk end is seen and the closing item is sent. the change walk
//  handles one key per cycle in the lowest-set-bit finder unless m_axis stalls.
//  the next scan is taken once the closing item sits in the output register.
//  a stall on m_axis holds the walk whenever a full pair or the closing item
//  must leave. reset clears the previous scan to all keys up.
// ----------------------------------------------------------------------------
module key_matrix_change_encoder #(
  parameter int ROWS   = 5,
  parameter int COLS   = 14,
  parameter int LAYERS = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // row0_bits, row1_bits, row2_bits, row3_bits, row4_bits, zero pad
  input  logic [kmce_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // first_valid, first_press, first_key, first_code, second_valid,
  // second_press, second_key, second_code, layer, debug_unlock,
  // send_report, zero pad
  output logic [kmce_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);
  import kmce_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  kmce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // change walk and result assembly
  kmce_datapath #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .LAYERS (LAYERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // closing item carries exactly one of unlock and report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[35] ^ m_axis_tdata[36]))
    else $error("closing item flags inconsistent");

  // items before the last are full pairs with no flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[0] && m_axis_tdata[17] && !m_axis_tdata[35] && !m_axis_tdata[36])
    else $error("non-final item not a full pair");

  // second slot is never used alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[0])
    else $error("second slot valid without first");

  // a scan is taken one at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("scan accepted while busy");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key matrix change encoder. Scans are driven on
// the input stream in random bursts, and the change events coming back are
// checked field by field against typed-in results or a scan-to-scan change encoder kept here.
// ----------------------------------------------------------------------------
module tb;
  import kmce_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int RAND_SCANS   = 204;
  localparam int SETTLE       = 100;

  // one full matrix sample, row r in bits [r]
  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] scan_t;

  // output item, laid out as m_axis_tdata from the highest bit down
  typedef struct packed {
    logic [2:0] pad;
    logic       report;
    logic       unlock;
    logic       layer;
    event_t     second;
    event_t     first;
  } evpair_t;

  typedef struct packed {
    evpair_t body;
    logic    last;
  } due_t;

  typedef struct {
    scan_t rows;
    bit    known;
    due_t  lit;
  } dir_row_t;

  // keycodes, one vector per layer and row, column 0 leftmost
  localparam logic [0:9][111:0] KEYROWS = {
    112'h29_1E_1F_20_21_22_23_24_25_26_27_2D_2E_2A,
    112'h2B_14_1A_08_15_17_1C_18_0C_12_13_2F_30_31,
    112'h39_04_16_07_09_0A_0B_0D_0E_0F_33_34_00_28,
    112'hE1_00_1D_1B_06_19_05_11_10_36_37_38_E5_00,
    112'hE0_E3_E2_00_00_2C_00_00_00_50_52_51_4F_00,
    112'h35_3A_3B_3C_3D_3E_3F_40_41_42_43_44_45_4C,
    112'h00_00_00_00_00_00_00_00_00_00_48_4A_4D_49,
    112'h00_00_00_00_00_00_00_00_00_00_00_00_00_00,
    112'h00_00_00_00_F5_00_F0_00_7F_00_F1_F2_00_00,
    112'h00_00_00_00_00_00_00_00_00_F3_81_80_F4_00
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  scan_t    prev_rows;
  scan_t    held;
  due_t     scan_results[$];
  due_t     due_q[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;
  int       rdy_left = 0;
  int       rdy_mode = 0;
  logic [7:0] rdy_pat = 8'hFF;

  key_matrix_change_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic event_t mk_ev(logic v, logic p, logic [KEY_W-1:0] k,
                                   logic [CODE_W-1:0] c);
    event_t e;
    e.valid = v;
    e.press = p;
    e.key   = k;
    e.code  = c;
    return e;
  endfunction

  // single closing item of a scan
  function automatic due_t mk_res(event_t f, event_t s, logic lay, logic unl,
                                  logic rep);
    due_t d;
    d = '0;
    d.body.first  = f;
    d.body.second = s;
    d.body.layer  = lay;
    d.body.unlock = unl;
    d.body.report = rep;
    d.last        = 1'b1;
    return d;
  endfunction

  // change encoder: events of one scan, two per item, into scan_results
  task automatic encode_scan(input scan_t cur);
    logic    lay;
    logic    unl;
    logic    have;
    evpair_t body;
    event_t  ev;
    due_t    d;
    scan_results.delete();
    lay  = cur[SHIFT_ROW][LAYER_BIT];
    unl  = (cur[SHIFT_ROW] & 14'h1001) == 14'h1001;
    have = 1'b0;
    body = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (cur[r][c] != prev_rows[r][c]) begin
          ev = mk_ev(1'b1, cur[r][c], KEY_W'(r * NUM_COLS + c),
                     KEYROWS[lay * NUM_ROWS + r][(13 - c) * 8 +: 8]);
          if (!have) begin
            body       = '0;
            body.layer = lay;
            body.first = ev;
            have       = 1'b1;
          end else begin
            body.second = ev;
            d.body      = body;
            d.last      = 1'b0;
            scan_results.push_back(d);
            have        = 1'b0;
          end
        end
      end
    end
    // closing item: pending odd event, empty scan, or the last full pair
    if (have) begin
      d.body = body;
    end else if (scan_results.size() == 0) begin
      d            = '0;
      d.body.layer = lay;
    end else begin
      d = scan_results.pop_back();
    end
    d.body.unlock = unl;
    d.body.report = !unl;
    d.last        = 1'b1;
    scan_results.push_back(d);
    prev_rows = cur;
  endtask

  // drive one scan, wait for acceptance, then maybe idle between bursts
  task automatic send_scan(input scan_t s, input bit known, input due_t lit);
    int gap;
    s_axis_tdata  <= {2'b00, s};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    encode_scan(s);
    if (known) due_q.push_back(lit);
    else foreach (scan_results[i]) due_q.push_back(scan_results[i]);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // hold off the sender until every queued item has come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_dir(logic [13:0] r0, logic [13:0] r1, logic [13:0] r2,
                         logic [13:0] r3, logic [13:0] r4, bit known,
                         due_t lit);
    dir_row_t d;
    d.rows  = {r4, r3, r2, r1, r0};
    d.known = known;
    d.lit   = lit;
    dir_rows.push_back(d);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches < 100)
        $display("%0t %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // receiver stall pattern, switching between free, random and rotating
  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_left <= $urandom_range(20, 300);
      rdy_mode <= $urandom_range(0, 2);
      rdy_pat  <= 8'($urandom);
    end else begin
      rdy_left <= rdy_left - 1;
      rdy_pat  <= {rdy_pat[6:0], rdy_pat[7]};
    end
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= rdy_pat[0] | (rdy_pat == 8'h00);
    endcase
  end

  // output checker
  always @(posedge clk_i) begin
    due_t    want;
    evpair_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches < 100)
          $display("%0t unexpected item expected none actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = due_q.pop_front();
        check_field("first_valid", want.body.first.valid, got.first.valid);
        check_field("first_press", want.body.first.press, got.first.press);
        check_field("first_key", want.body.first.key, got.first.key);
        check_field("first_code", want.body.first.code, got.first.code);
        check_field("second_valid", want.body.second.valid, got.second.valid);
        check_field("second_press", want.body.second.press, got.second.press);
        check_field("second_key", want.body.second.key, got.second.key);
        check_field("second_code", want.body.second.code, got.second.code);
        check_field("layer", want.body.layer, got.layer);
        check_field("debug_unlock", want.body.unlock, got.unlock);
        check_field("send_report", want.body.report, got.report);
        check_field("pad", want.body.pad, got.pad);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // stimulus
  initial begin
    event_t none;
    scan_t  nxt;
    none      = '0;
    prev_rows = '0;
    held      = '0;

    // directed scans, single-item results typed in where obvious
    add_dir(14'h0000, 0, 0, 14'h0000, 0, 1, mk_res(none, none, 0, 0, 1));
    add_dir(14'h0001, 0, 0, 14'h0000, 0, 1,
            mk_res(mk_ev(1, 1, 0, 8'h29), none, 0, 0, 1));
    add_dir(14'h0000, 0, 0, 14'h0000, 0, 1,
            mk_res(mk_ev(1, 0, 0, 8'h29), none, 0, 0, 1));
    // both shifts held
    add_dir(14'h0000, 0, 0, 14'h1001, 0, 1,
            mk_res(mk_ev(1, 1, 42, 8'hE1), mk_ev(1, 1, 54, 8'hE5), 0, 1, 0));
    // layer key pressed with shifts still down
    add_dir(14'h0000, 0, 0, 14'h3001, 0, 1,
            mk_res(mk_ev(1, 1, 55, 8'h00), none, 1, 1, 0));
    // shift releases looked up on the upper layer
    add_dir(14'h0000, 0, 0, 14'h2000, 0, 1,
            mk_res(mk_ev(1, 0, 42, 8'h00), mk_ev(1, 0, 54, 8'h00), 1, 0, 1));
    add_dir(14'h0000, 0, 0, 14'h0000, 0, 1,
            mk_res(mk_ev(1, 0, 55, 8'h00), none, 0, 0, 1));
    // every key pressed, then no change, then every key released
    add_dir(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 0, '0);
    add_dir(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1,
            mk_res(none, none, 1, 1, 0));
    add_dir(14'h0000, 0, 0, 14'h0000, 0, 0, '0);
    // highest key position
    add_dir(14'h0000, 0, 0, 14'h0000, 14'h2000, 1,
            mk_res(mk_ev(1, 1, 69, 8'h00), none, 0, 0, 1));
    add_dir(14'h0000, 0, 0, 14'h1000, 14'h3E00, 0, '0);
    // media and custom keys on the upper layer
    add_dir(14'h0000, 0, 0, 14'h2D51, 14'h1E00, 0, '0);
    add_dir(14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA, 0, '0);
    add_dir(14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, 0, '0);
    add_dir(14'h0000, 14'h3C00, 0, 14'h0000, 0, 0, '0);
    add_dir(14'h0000, 14'h3C00, 0, 14'h2000, 0, 0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_scan(dir_rows[i].rows, dir_rows[i].known, dir_rows[i].lit);
      held = dir_rows[i].rows;
    end
    drain();

    // random scans, mostly a few keys changing against the last scan
    for (int i = 0; i < RAND_SCANS; i++) begin
      nxt = held;
      case ($urandom_range(0, 9))
        0: ;
        1: for (int r = 0; r < NUM_ROWS; r++) nxt[r] = 14'($urandom);
        2: begin
          nxt[SHIFT_ROW] = nxt[SHIFT_ROW] | 14'h1001;
          nxt[$urandom_range(0, 4)][$urandom_range(0, 13)] ^= 1'b1;
        end
        3: nxt[SHIFT_ROW][LAYER_BIT] = !nxt[SHIFT_ROW][LAYER_BIT];
        4: nxt = ($urandom_range(0, 1) == 0) ? '0 : '1;
        default: begin
          repeat ($urandom_range(1, 4))
            nxt[$urandom_range(0, 4)][$urandom_range(0, 13)] ^= 1'b1;
        end
      endcase
      if (i == RAND_SCANS / 2) drain();
      send_scan(nxt, 0, '0);
      held = nxt;
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
